### rtl/cbh_pkg.sv
// Shared types and constants of the CBOR head encoder.
package cbh_pkg;

  localparam int unsigned ValueW    = 64;
  localparam int unsigned OffsetW   = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned JobBytes  = 5;
  localparam int unsigned CntW      = 3;
  localparam int unsigned FifoDepthDefault = 4;
  localparam logic [OffsetW-1:0] CapacityReset = 16'd1024;

  typedef enum logic [2:0] {
    CMD_RESTART = 3'd0,
    CMD_UINT    = 3'd1,
    CMD_SINT    = 3'd2,
    CMD_BYTES   = 3'd3,
    CMD_TEXT    = 3'd4,
    CMD_MAP     = 3'd5,
    CMD_ARRAY   = 3'd6,
    CMD_PAYLOAD = 3'd7
  } cmd_e;

  // Major type, already placed in the top three bits of the initial byte.
  localparam logic [ByteW-1:0] MajUint  = 8'h00;
  localparam logic [ByteW-1:0] MajNeg   = 8'h20;
  localparam logic [ByteW-1:0] MajBytes = 8'h40;
  localparam logic [ByteW-1:0] MajText  = 8'h60;
  localparam logic [ByteW-1:0] MajArray = 8'h80;
  localparam logic [ByteW-1:0] MajMap   = 8'hA0;

  // Additional-info codes for one, two and four argument bytes.
  localparam logic [4:0] Info8  = 5'd24;
  localparam logic [4:0] Info16 = 5'd25;
  localparam logic [4:0] Info32 = 5'd26;

  // One queued run of bytes: bytes[0] goes out first.
  typedef struct packed {
    logic [JobBytes-1:0][ByteW-1:0] bytes;
    logic [OffsetW-1:0]             pos;
    logic [CntW-1:0]                cnt;
  } job_t;

endpackage

### rtl/cbh_front.sv
// Command front end: classify, track buffer state, build byte runs.
module cbh_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [cbh_pkg::OffsetW-1:0] capacity_i,
  input  logic                      cmd_valid_i,
  output logic                      cmd_ready_o,
  input  logic [2:0]                cmd_i,
  input  logic [cbh_pkg::ValueW-1:0] value_i,
  input  logic [cbh_pkg::ByteW-1:0] payload_byte_i,
  input  logic                      queue_full_i,
  output logic                      push_o,
  output cbh_pkg::job_t             job_o
);
  import cbh_pkg::*;

  logic [OffsetW-1:0] write_offset_q, write_offset_d;
  logic [OffsetW-1:0] payload_left_q, payload_left_d;

  cmd_e             cmd;
  logic             accept;
  logic             is_head;
  logic [ValueW-1:0] arg;
  logic [ByteW-1:0] major;
  logic [OffsetW:0] room;
  logic [OffsetW:0] pl_room;
  logic             wo_lt_cap;
  logic             wo_le_cap;
  logic             arg_fits;
  logic [CntW-1:0]  need;
  logic             head_ok;
  logic             pl_ok;

  assign cmd         = cmd_e'(cmd_i);
  assign cmd_ready_o = !queue_full_i;
  assign accept      = cmd_valid_i && cmd_ready_o;

  assign arg       = (cmd == CMD_SINT && value_i[ValueW-1]) ? ~value_i : value_i;
  assign room      = {1'b0, capacity_i} - {1'b0, write_offset_q};
  assign wo_lt_cap = write_offset_q < capacity_i;
  assign wo_le_cap = write_offset_q <= capacity_i;
  assign arg_fits  = (arg[63:32] == '0);

  always_comb begin
    if (arg[31:16] != '0) begin
      need = CntW'(5);
    end else if (arg[15:8] != '0) begin
      need = CntW'(3);
    end else if (arg[7:0] >= 8'(Info8)) begin
      need = CntW'(2);
    end else begin
      need = CntW'(1);
    end
  end

  always_comb begin
    is_head = 1'b1;
    major   = MajUint;
    case (cmd)
      CMD_UINT:  major = MajUint;
      CMD_SINT:  major = value_i[ValueW-1] ? MajNeg : MajUint;
      CMD_BYTES: major = MajBytes;
      CMD_TEXT:  major = MajText;
      CMD_MAP:   major = MajMap;
      CMD_ARRAY: major = MajArray;
      default:   is_head = 1'b0;
    endcase
  end

  assign head_ok = is_head && arg_fits && wo_lt_cap &&
                   ({{(OffsetW+1-CntW){1'b0}}, need} <= room);

  // Room left for the string body once the head has been placed.
  assign pl_room = head_ok ? room - {{(OffsetW+1-CntW){1'b0}}, need} : room;
  assign pl_ok   = wo_le_cap && (value_i[63:16] == '0) &&
                   ({1'b0, value_i[15:0]} <= pl_room);

  always_comb begin
    write_offset_d = write_offset_q;
    payload_left_d = payload_left_q;
    push_o         = 1'b0;
    job_o.pos      = write_offset_q;
    job_o.cnt      = need;
    job_o.bytes    = '0;
    case (need)
      CntW'(1): job_o.bytes[0] = major | {3'b000, arg[4:0]};
      CntW'(2): begin
        job_o.bytes[0] = major | {3'b000, Info8};
        job_o.bytes[1] = arg[7:0];
      end
      CntW'(3): begin
        job_o.bytes[0] = major | {3'b000, Info16};
        job_o.bytes[1] = arg[15:8];
        job_o.bytes[2] = arg[7:0];
      end
      default: begin
        job_o.bytes[0] = major | {3'b000, Info32};
        job_o.bytes[1] = arg[31:24];
        job_o.bytes[2] = arg[23:16];
        job_o.bytes[3] = arg[15:8];
        job_o.bytes[4] = arg[7:0];
      end
    endcase
    if (accept) begin
      if (cmd == CMD_PAYLOAD) begin
        if (payload_left_q != '0) begin
          payload_left_d = payload_left_q - OffsetW'(1);
          if (wo_lt_cap) begin
            push_o         = 1'b1;
            job_o.cnt      = CntW'(1);
            job_o.bytes    = '0;
            job_o.bytes[0] = payload_byte_i;
            write_offset_d = write_offset_q + OffsetW'(1);
          end
        end
      end else begin
        payload_left_d = '0;
        if (cmd == CMD_RESTART) begin
          write_offset_d = '0;
        end
        if (head_ok) begin
          push_o         = 1'b1;
          write_offset_d = write_offset_q + {{(OffsetW-CntW){1'b0}}, need};
        end
        if ((cmd == CMD_BYTES || cmd == CMD_TEXT) && pl_ok) begin
          payload_left_d = value_i[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_offset_q <= '0;
      payload_left_q <= '0;
    end else begin
      write_offset_q <= write_offset_d;
      payload_left_q <= payload_left_d;
    end
  end

  // A run is always one, two, three or five bytes long.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (job_o.cnt == CntW'(1) || job_o.cnt == CntW'(2) ||
                job_o.cnt == CntW'(3) || job_o.cnt == CntW'(5)))
    else $error("bad run length");

  // A head never runs past the buffer end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && cmd != CMD_PAYLOAD) |=> (write_offset_q <= $past(capacity_i)))
    else $error("head overran buffer");

endmodule

### rtl/cbh_fifo.sv
// Short queue of byte runs between front end and serializer.
module cbh_fifo #(
  parameter int unsigned Depth = cbh_pkg::FifoDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cbh_pkg::job_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output cbh_pkg::job_t rdata_o
);
  import cbh_pkg::*;

  localparam int unsigned AddrW = $clog2(Depth);

  job_t             mem_q [Depth];
  logic [AddrW:0]   wptr_q, rptr_q;

  assign valid_o = (wptr_q != rptr_q);
  assign full_o  = (wptr_q[AddrW] != rptr_q[AddrW]) &&
                   (wptr_q[AddrW-1:0] == rptr_q[AddrW-1:0]);
  assign rdata_o = mem_q[rptr_q[AddrW-1:0]];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wptr_q[AddrW-1:0]] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i && valid_o) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

endmodule

### rtl/cbh_back.sv
// Serializer: walk each queued run out one byte per word.
module cbh_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_valid_i,
  input  cbh_pkg::job_t               job_i,
  output logic                        pop_o,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output logic [cbh_pkg::ByteW-1:0]   out_byte_o,
  output logic [cbh_pkg::OffsetW-1:0] byte_position_o,
  output logic                        last_o
);
  import cbh_pkg::*;

  logic [CntW-1:0]    idx_q, idx_d;
  logic               valid_q;
  logic [ByteW-1:0]   byte_q;
  logic [OffsetW-1:0] pos_q;
  logic               last_q;
  logic               advance;
  logic               at_last;

  assign advance = job_valid_i && (!valid_q || m_ready_i);
  assign at_last = (idx_q == job_i.cnt - CntW'(1));
  assign pop_o   = advance && at_last;

  always_comb begin
    idx_d = idx_q;
    if (advance) begin
      idx_d = at_last ? '0 : idx_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      idx_q <= idx_d;
      if (advance) begin
        valid_q <= 1'b1;
      end else if (m_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_q <= job_i.bytes[idx_q];
      pos_q  <= job_i.pos + {{(OffsetW-CntW){1'b0}}, idx_q};
      last_q <= at_last;
    end
  end

  assign m_valid_o       = valid_q;
  assign out_byte_o      = byte_q;
  assign byte_position_o = pos_q;
  assign last_o          = last_q;

  // Byte index stays inside the run being walked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> (idx_q < job_i.cnt))
    else $error("run index out of range");

endmodule

### rtl/cbor_head_encoder_core.sv
// Top level of the CBOR data-item head encoder.
// A command's bytes pass through the run queue and then the serializer's output register on their way out.
// Throughput: one command per cycle enters while the run queue has room; one byte per cycle
//   leaves while the master side is ready; a multi-byte head holds the serializer until its last byte is taken.
// The run queue (FifoDepth runs) sets how far the command side can run ahead of the byte side.
// Reset: write offset, pending payload count and queue clear; capacity returns to 1024.
module cbor_head_encoder_core #(
  parameter int unsigned FifoDepth = cbh_pkg::FifoDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Capacity register write.
  input  logic                        cfg_we_i,
  input  logic [cbh_pkg::OffsetW-1:0] cfg_wdata_i,
  // Command words.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [71:0]                 s_axis_tdata,  // value[63:0], payload_byte[71:64]
  input  logic [2:0]                  s_axis_tuser,  // cmd[2:0]
  // Encoded byte words.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [23:0]                 m_axis_tdata,  // out_byte[7:0], byte_position[23:8]
  output logic                        m_axis_tlast   // last_of_run
);
  import cbh_pkg::*;

  logic [OffsetW-1:0] capacity_q;
  logic               push;
  job_t               push_job;
  logic               queue_full;
  logic               queue_valid;
  job_t               queue_job;
  logic               pop;
  logic [ByteW-1:0]   out_byte;
  logic [OffsetW-1:0] byte_position;

  // Capacity register: the user must write it only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapacityReset;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  // Front end: decide each command at once and push its bytes as one run.
  cbh_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .capacity_i     (capacity_q),
    .cmd_valid_i    (s_axis_tvalid),
    .cmd_ready_o    (s_axis_tready),
    .cmd_i          (s_axis_tuser),
    .value_i        (s_axis_tdata[63:0]),
    .payload_byte_i (s_axis_tdata[71:64]),
    .queue_full_i   (queue_full),
    .push_o         (push),
    .job_o          (push_job)
  );

  // Run queue decouples command intake from byte output.
  cbh_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_job),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .rdata_o (queue_job)
  );

  // Back end: serialize each run through the output register.
  cbh_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (queue_valid),
    .job_i           (queue_job),
    .pop_o           (pop),
    .m_valid_o       (m_axis_tvalid),
    .m_ready_i       (m_axis_tready),
    .out_byte_o      (out_byte),
    .byte_position_o (byte_position),
    .last_o          (m_axis_tlast)
  );

  assign m_axis_tdata = {byte_position, out_byte};

endmodule

### sim/testbench.sv
// Self-checking testbench for the CBOR head encoder core: commands in, encoded byte words out.
`timescale 1ns / 1ps

module testbench;
  import cbh_pkg::*;

  localparam int unsigned CycleLimit = 150000;
  localparam int unsigned DrainPause = 8;

  // One command word as the sender presents it.
  typedef struct {
    cmd_e             op;
    logic [63:0]      val;
    logic [ByteW-1:0] pb;
  } enc_cmd_t;

  // One encoded byte word as it should leave the core.
  typedef struct {
    logic [ByteW-1:0]   data;
    logic [OffsetW-1:0] pos;
    logic               last;
  } enc_byte_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [OffsetW-1:0] cfg_wdata_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [71:0]        s_axis_tdata = '0;  // value[63:0], payload_byte[71:64]
  logic [2:0]         s_axis_tuser = '0;  // cmd[2:0]
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [23:0]        m_axis_tdata;       // out_byte[7:0], byte_position[23:8]
  logic               m_axis_tlast;       // last_of_run

  // Commands waiting for the driver, and the byte words the core still owes us.
  enc_cmd_t  cmd_pending_q[$];
  enc_byte_t enc_bytes_q[$];
  enc_cmd_t  cur_cmd;

  // Shadow copy of the core's state and its capacity register.
  logic [OffsetW-1:0] cap = CapacityReset;
  logic [OffsetW-1:0] wr_off = '0;
  logic [OffsetW-1:0] pay_left = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cmds_queued = 0;
  int unsigned cmds_taken = 0;
  int unsigned bytes_seen = 0;
  int unsigned cap_writes = 0;
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;

  cbor_head_encoder_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Encoding predictor
  // ---------------------------------------------------------------------------

  // Place one byte at the current write offset and advance the offset.
  function automatic void emit_byte(logic [ByteW-1:0] b);
    enc_byte_t e;
    e.data = b;
    e.pos  = wr_off;
    e.last = 1'b0;
    enc_bytes_q.push_back(e);
    wr_off = wr_off + 16'd1;
  endfunction

  // Emit a head (initial byte plus big-endian argument) if it fits whole;
  // return the number of bytes emitted.
  function automatic int unsigned emit_head(logic [ByteW-1:0] major, logic [63:0] arg);
    int unsigned need;
    int unsigned i;
    logic [4:0]  info;
    if (wr_off >= cap) return 0;
    if (arg < 64'd24) begin
      need = 1;
      info = arg[4:0];
    end else if (arg <= 64'hFF) begin
      need = 2;
      info = Info8;
    end else if (arg <= 64'hFFFF) begin
      need = 3;
      info = Info16;
    end else if (arg <= 64'hFFFF_FFFF) begin
      need = 5;
      info = Info32;
    end else begin
      // Arguments wider than 32 bits have no encoding here.
      return 0;
    end
    // Drop the whole head when the rest of the buffer is too short.
    if (need > 32'(cap) - 32'(wr_off)) return 0;
    emit_byte(major | {3'b000, info});
    for (i = need - 1; i > 0; i--) emit_byte(arg[8*(i-1) +: 8]);
    return need;
  endfunction

  // Work out the byte words that one accepted command causes.
  function automatic void encode_cmd(enc_cmd_t c);
    int unsigned n;
    enc_byte_t   e;
    n = 0;
    if (c.op == CMD_PAYLOAD) begin
      // Count a pending payload byte off even when it lands beyond capacity.
      if (pay_left != '0) begin
        pay_left = pay_left - 16'd1;
        if (wr_off < cap) begin
          emit_byte(c.pb);
          n = 1;
        end
      end
    end else begin
      // Any other command cancels what is left of a payload.
      pay_left = '0;
      case (c.op)
        CMD_RESTART: wr_off = '0;
        CMD_UINT:    n = emit_head(MajUint, c.val);
        CMD_SINT:    n = c.val[63] ? emit_head(MajNeg, ~c.val) : emit_head(MajUint, c.val);
        CMD_BYTES, CMD_TEXT: begin
          n = emit_head((c.op == CMD_BYTES) ? MajBytes : MajText, c.val);
          // Open the payload only if all of it fits behind the head.
          if (wr_off <= cap && c.val <= 64'(cap - wr_off)) pay_left = c.val[15:0];
        end
        CMD_MAP:     n = emit_head(MajMap, c.val);
        default:     n = emit_head(MajArray, c.val);
      endcase
    end
    if (n > 0) begin
      e = enc_bytes_q.pop_back();
      e.last = 1'b1;
      enc_bytes_q.push_back(e);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Command driver: present the next pending word, hold it until taken
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic     show;
    enc_cmd_t nxt;
    show = s_axis_tvalid;
    if (!rst_ni) begin
      show = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        encode_cmd(cur_cmd);
        cmds_taken++;
        show = 1'b0;
      end
      // Drop valid for a random gap, or advance to the next word.
      if (!show && cmd_pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = cmd_pending_q.pop_front();
        cur_cmd = nxt;
        s_axis_tdata <= {nxt.pb, nxt.val};
        s_axis_tuser <= nxt.op;
        show = 1'b1;
      end
    end
    s_axis_tvalid <= show;
  end

  // ---------------------------------------------------------------------------
  // Byte monitor: stall at random, check each accepted word against the oldest
  // expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    enc_byte_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      bytes_seen++;
      if (enc_bytes_q.size() == 0) begin
        $display("%0t: unexpected word: byte %02h pos %0d last %0b", $time,
                 m_axis_tdata[7:0], m_axis_tdata[23:8], m_axis_tlast);
        errors++;
      end else begin
        want = enc_bytes_q.pop_front();
        if (m_axis_tdata[7:0] !== want.data) begin
          $display("%0t: out_byte mismatch: expected %02h, actual %02h", $time,
                   want.data, m_axis_tdata[7:0]);
          errors++;
        end
        if (m_axis_tdata[23:8] !== want.pos) begin
          $display("%0t: byte_position mismatch: expected %0d, actual %0d", $time,
                   want.pos, m_axis_tdata[23:8]);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: last_of_run mismatch: expected %0b, actual %0b", $time,
                   want.last, m_axis_tlast);
          errors++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_cmd(cmd_e op, logic [63:0] val, logic [ByteW-1:0] pb);
    enc_cmd_t c;
    c.op  = op;
    c.val = val;
    c.pb  = pb;
    cmd_pending_q.push_back(c);
    cmds_queued++;
  endtask

  // Hold the sender until every command is taken and every word has come,
  // then let the core settle.
  task automatic wait_drained();
    while (cmds_taken != cmds_queued || enc_bytes_q.size() != 0) @(negedge clk_i);
    repeat (DrainPause) @(posedge clk_i);
  endtask

  // Write the capacity register while the core is idle.
  task automatic write_capacity(logic [OffsetW-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cap = v;
    cap_writes++;
  endtask

  // Argument drawn from every size class, the boundaries among them.
  function automatic logic [63:0] pick_arg();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(5))
      0: return 64'($urandom_range(23));
      1: return 64'($urandom_range(255, 24));
      2: return 64'($urandom_range(65535, 256));
      3: return {32'd0, r[31:16] | 16'h0001, r[15:0]};
      4: begin
        if (r[63:32] == '0) r[32] = 1'b1;
        return r;
      end
      default: begin
        case ($urandom_range(9))
          0: return 64'd0;
          1: return 64'd23;
          2: return 64'd24;
          3: return 64'hFF;
          4: return 64'h100;
          5: return 64'hFFFF;
          6: return 64'h1_0000;
          7: return 64'hFFFF_FFFF;
          8: return 64'h1_0000_0000;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // Queue about n counted commands: mostly heads and well-formed strings with
  // random content, some truncated or overlong strings and some noise.
  task automatic queue_random(int unsigned n);
    int unsigned made;
    int unsigned len;
    int unsigned sent;
    int unsigned i;
    logic [63:0] a;
    made = 0;
    while (made < n) begin
      case ($urandom_range(99)) inside
        [0:9]: begin
          queue_cmd(CMD_RESTART, {$urandom, $urandom}, 8'($urandom));
          made++;
        end
        [10:49]: begin
          a = pick_arg();
          case ($urandom_range(3))
            0: queue_cmd(CMD_UINT, a, 8'($urandom));
            1: queue_cmd(CMD_SINT, $urandom_range(1) ? ~a : a, 8'($urandom));
            2: queue_cmd(CMD_MAP, a, 8'($urandom));
            default: queue_cmd(CMD_ARRAY, a, 8'($urandom));
          endcase
          made++;
        end
        [50:84]: begin
          len = ($urandom_range(99) < 85) ? $urandom_range(6) : $urandom_range(40, 20);
          queue_cmd($urandom_range(1) ? CMD_BYTES : CMD_TEXT, 64'(len), 8'($urandom));
          // Mostly the exact payload; sometimes cut short or run over.
          case ($urandom_range(19))
            0, 1:    sent = (len > 0) ? $urandom_range(len - 1) : 0;
            2:       sent = len + $urandom_range(3, 1);
            default: sent = len;
          endcase
          for (i = 0; i < sent; i++) queue_cmd(CMD_PAYLOAD, {$urandom, $urandom}, 8'($urandom));
          made += sent + 1;
        end
        default: begin
          if ($urandom_range(1)) begin
            // Stray payload byte: usually ignored, so leave it uncounted.
            queue_cmd(CMD_PAYLOAD, {$urandom, $urandom}, 8'($urandom));
          end else begin
            queue_cmd(cmd_e'($urandom_range(7)), {$urandom, $urandom}, 8'($urandom));
            made++;
          end
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset capacity, no idling: every command, each head
    // size boundary, signed extremes, wide arguments, payload handling.
    queue_cmd(CMD_RESTART, '1, 8'hFF);
    queue_cmd(CMD_UINT, 64'd0, 8'hA5);
    queue_cmd(CMD_UINT, 64'd23, 8'h00);
    queue_cmd(CMD_UINT, 64'd24, 8'h00);
    queue_cmd(CMD_UINT, 64'hFF, 8'h00);
    queue_cmd(CMD_UINT, 64'h100, 8'h00);
    queue_cmd(CMD_UINT, 64'hFFFF, 8'h00);
    queue_cmd(CMD_UINT, 64'h1_0000, 8'h00);
    queue_cmd(CMD_UINT, 64'hFFFF_FFFF, 8'h00);
    queue_cmd(CMD_UINT, 64'h1_0000_0000, 8'h00);
    queue_cmd(CMD_UINT, '1, 8'h00);
    queue_cmd(CMD_SINT, '1, 8'h00);
    queue_cmd(CMD_SINT, -64'sd24, 8'h00);
    queue_cmd(CMD_SINT, -64'sd25, 8'h00);
    queue_cmd(CMD_SINT, -64'sh1_0000_0000, 8'h00);
    queue_cmd(CMD_SINT, 64'h8000_0000_0000_0000, 8'h00);
    queue_cmd(CMD_SINT, 64'h7FFF_FFFF_FFFF_FFFF, 8'h00);
    queue_cmd(CMD_MAP, 64'd2, 8'h00);
    queue_cmd(CMD_ARRAY, 64'd300, 8'h00);
    queue_cmd(CMD_BYTES, 64'd2, 8'h00);
    queue_cmd(CMD_PAYLOAD, 64'd0, 8'h00);
    queue_cmd(CMD_PAYLOAD, '1, 8'hFF);
    // Payload byte with nothing pending.
    queue_cmd(CMD_PAYLOAD, 64'd0, 8'h5A);
    // Text cut short by another command.
    queue_cmd(CMD_TEXT, 64'd3, 8'h00);
    queue_cmd(CMD_PAYLOAD, 64'd0, 8'h41);
    queue_cmd(CMD_ARRAY, 64'd0, 8'h00);
    queue_cmd(CMD_PAYLOAD, 64'd0, 8'h42);
    // Payload longer than the buffer: head goes out, bytes are discarded.
    queue_cmd(CMD_BYTES, 64'd2000, 8'h00);
    queue_cmd(CMD_PAYLOAD, 64'd0, 8'h77);
    wait_drained();

    // Capacity lowered under a pending payload: bytes beyond it still count off.
    queue_cmd(CMD_RESTART, 64'd0, 8'h00);
    queue_cmd(CMD_TEXT, 64'd12, 8'h00);
    for (int i = 0; i < 4; i++) queue_cmd(CMD_PAYLOAD, 64'd0, 8'(8'h30 + i));
    wait_drained();
    write_capacity(16'd3);
    for (int i = 0; i < 4; i++) queue_cmd(CMD_PAYLOAD, 64'd0, 8'(8'h60 + i));
    queue_cmd(CMD_UINT, 64'd5, 8'h00);
    queue_cmd(CMD_BYTES, 64'd0, 8'h00);
    queue_cmd(CMD_RESTART, 64'd0, 8'h00);
    queue_cmd(CMD_UINT, 64'h1_0000, 8'h00);   // needs five bytes, three left
    queue_cmd(CMD_UINT, 64'd1000, 8'h00);
    queue_cmd(CMD_UINT, 64'd0, 8'h00);
    queue_cmd(CMD_BYTES, 64'd0, 8'h00);
    wait_drained();

    // Zero capacity: nothing may come out.
    write_capacity(16'd0);
    queue_cmd(CMD_UINT, 64'd0, 8'h00);
    queue_cmd(CMD_RESTART, 64'd0, 8'h00);
    queue_cmd(CMD_TEXT, 64'd0, 8'h00);
    queue_cmd(CMD_PAYLOAD, 64'd0, 8'h11);
    queue_cmd(CMD_MAP, 64'd1, 8'h00);
    wait_drained();

    // Random phases; each one ends with the sender held until the core drains.
    write_capacity(16'hFFFF);
    queue_cmd(CMD_RESTART, 64'd0, 8'h00);
    queue_random(96);
    wait_drained();

    write_capacity(16'd40);
    send_idle_pct = 53;
    queue_cmd(CMD_RESTART, 64'd0, 8'h00);
    queue_random(96);
    wait_drained();

    write_capacity(16'($urandom_range(300, 16)));
    send_idle_pct  = 0;
    recv_stall_pct = 53;
    queue_cmd(CMD_RESTART, 64'd0, 8'h00);
    queue_random(96);
    wait_drained();

    write_capacity(CapacityReset);
    send_idle_pct  = 22;
    recv_stall_pct = 22;
    queue_cmd(CMD_RESTART, 64'd0, 8'h00);
    queue_random(96);
    wait_drained();

    $display("Covered %0d commands and %0d encoded bytes over %0d capacity settings,",
             cmds_taken, bytes_seen, cap_writes);
    $display("with idle sender, stalled receiver, both and neither; %0d mismatches.", errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
